### rtl/tcgw_pkg.sv
// ----------------------------------------------------------------------------
// tcgw_pkg
// Types, constants and helpers shared by the text console glyph writer.
// ----------------------------------------------------------------------------
package tcgw_pkg;

  localparam int CHAR_HEIGHT = 12;
  localparam int CHAR_WIDTH  = 8;
  localparam int GLYPH_COUNT = 129;

  localparam int FONT_DEPTH  = GLYPH_COUNT * CHAR_HEIGHT;
  localparam int FA_W        = $clog2(FONT_DEPTH);
  localparam int ROW_W       = 4;
  localparam int CUR_W       = 11;
  localparam int ADDR_W      = 20;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [7:0]       BACKSPACE_CODE  = 8'd8;
  localparam logic [7:0]       SPACE_CODE      = 8'd32;
  localparam logic [7:0]       HIGH_CODE_LIMIT = 8'd128;
  localparam logic [7:0]       SUBST_GLYPH     = 8'd4;
  localparam logic [CUR_W-1:0] CUR_MAX         = 11'd2047;
  localparam logic [7:0]       COL_MASK        = 8'(16'hFF00 >> CHAR_WIDTH);
  localparam logic [ROW_W-1:0] LAST_ROW_IDX    = ROW_W'(CHAR_HEIGHT - 1);

  localparam logic       OP_PUT  = 1'b0;
  localparam logic       OP_LOAD = 1'b1;

  localparam logic [2:0] REG_LINE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_TEXT_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TEXT_TOP    = 3'd2;
  localparam logic [2:0] REG_FG_COLOR    = 3'd3;
  localparam logic [2:0] REG_BG_COLOR    = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [19:0] pixel_address;
    logic [7:0]  row_bits;
    logic        last_row;
    logic [10:0] cursor_col;
    logic [10:0] cursor_row;
  } out_item_t;

  typedef struct packed {
    logic [10:0] line_width;
    logic [10:0] text_area_height;
    logic [9:0]  text_top_row;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } cfg_t;

  // work queued from front to back
  typedef struct packed {
    logic             is_load;
    logic [FA_W-1:0]  font_addr;
    logic [7:0]       glyph_bits;
    logic [CUR_W-1:0] draw_x;
    logic [CUR_W-1:0] draw_y;
    logic [CUR_W-1:0] cur_x;
    logic [CUR_W-1:0] cur_y;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;

  function automatic logic [CUR_W-1:0] sat_add(input logic [CUR_W-1:0] a,
                                               input logic [CUR_W-1:0] b);
    logic [CUR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CUR_W] ? CUR_MAX : s[CUR_W-1:0];
  endfunction

  function automatic logic [CUR_W-1:0] sat_sub(input logic [CUR_W-1:0] a,
                                               input logic [CUR_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

### rtl/tcgw_front.sv
// ----------------------------------------------------------------------------
// tcgw_front
// Accepts items, keeps the cursor; puts and in-range loads become commands.
// ----------------------------------------------------------------------------
module tcgw_front import tcgw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  input  cfg_t     cfg,
  output logic     push,
  output cmd_t     cmd
);

  localparam logic [CUR_W-1:0] CW = CUR_W'(CHAR_WIDTH);
  localparam logic [CUR_W-1:0] CH = CUR_W'(CHAR_HEIGHT);

  logic [CUR_W-1:0] cursor_x, cursor_y;
  logic [CUR_W-1:0] x1, y1, x2, y2, cursor_x_next, cursor_y_next;
  logic             wrap, fits, is_bs, load_ok;
  logic [7:0]       glyph;

  always_comb begin
    wrap = (cursor_x != '0) && (cursor_x >= cfg.line_width);
    fits = ({1'b0, cursor_y} + 12'(2 * CHAR_HEIGHT)) <= {1'b0, cfg.text_area_height};
    x1 = cursor_x;
    y1 = cursor_y;
    if (wrap) begin
      if (fits) begin
        x1 = '0;
        y1 = sat_add(cursor_y, CH);
      end else begin
        x1 = sat_sub(cursor_x, CW);
      end
    end

    is_bs = (item.char_code == BACKSPACE_CODE);
    x2 = x1;
    y2 = y1;
    if (is_bs) begin
      if (x1 != '0) begin
        x2 = sat_sub(x1, CW);
      end else if (y1 != '0) begin
        y2 = sat_sub(y1, CH);
        x2 = sat_sub(cfg.line_width, CW);
      end
      cursor_x_next = x2;
      glyph = SPACE_CODE;
    end else begin
      cursor_x_next = sat_add(x1, CW);
      glyph = item.char_code;
    end
    cursor_y_next = y2;
    if (glyph > HIGH_CODE_LIMIT || 9'(glyph) >= 9'(GLYPH_COUNT)) begin
      glyph = SUBST_GLYPH;
    end

    load_ok = (9'(item.char_code) < 9'(GLYPH_COUNT)) &&
              (5'(item.glyph_row) < 5'(CHAR_HEIGHT));

    cmd.is_load    = (item.opcode == OP_LOAD);
    cmd.glyph_bits = item.glyph_bits;
    cmd.draw_x     = x2;
    cmd.draw_y     = y2;
    cmd.cur_x      = cursor_x_next;
    cmd.cur_y      = cursor_y_next;
    if (item.opcode == OP_LOAD) begin
      cmd.font_addr = FA_W'(item.char_code) * FA_W'(CHAR_HEIGHT) + FA_W'(item.glyph_row);
      push = accept && load_ok;
    end else begin
      cmd.font_addr = FA_W'(glyph) * FA_W'(CHAR_HEIGHT);
      push = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (accept && item.opcode == OP_PUT) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

endmodule

### rtl/tcgw_queue.sv
// ----------------------------------------------------------------------------
// tcgw_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module tcgw_queue import tcgw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/tcgw_back.sv
// ----------------------------------------------------------------------------
// tcgw_back
// Holds the font memory, writes font rows and draws one glyph row per cycle.
// ----------------------------------------------------------------------------
module tcgw_back import tcgw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  cmd_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      result_strobe,
  output out_item_t result
);

  logic [7:0]        font [FONT_DEPTH];
  back_state_t       state;
  logic [FA_W-1:0]   base;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] line_addr;
  logic [CUR_W-1:0]  dx, cx, cy;
  logic              s1_valid, s1_last;
  logic [ADDR_W-1:0] s1_addr;
  logic [CUR_W-1:0]  s1_cx, s1_cy;
  logic [7:0]        rd_data;
  logic              last_cycle;

  assign last_cycle = (state == ST_RUN) && (row == LAST_ROW_IDX);
  assign pop = !empty && ((state == ST_IDLE) || last_cycle);

  always_ff @(posedge clk) begin
    if (pop && head.is_load) begin
      font[head.font_addr] <= head.glyph_bits;
    end
    if (state == ST_RUN) begin
      rd_data <= font[base + FA_W'(row)];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      s1_addr <= line_addr + ADDR_W'(dx);
      s1_last <= last_cycle;
      s1_cx   <= cx;
      s1_cy   <= cy;
    end
    if (pop && !head.is_load) begin
      base      <= head.font_addr;
      row       <= '0;
      dx        <= head.draw_x;
      cx        <= head.cur_x;
      cy        <= head.cur_y;
      line_addr <= ADDR_W'(cfg.line_width) *
                   ADDR_W'(12'(cfg.text_top_row) + 12'(head.draw_y));
    end else if (state == ST_RUN) begin
      line_addr <= line_addr + ADDR_W'(cfg.line_width);
      row       <= row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      unique case (state)
        ST_IDLE: begin
          if (pop && !head.is_load) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_cycle && !(pop && !head.is_load)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result_strobe        = s1_valid;
  assign result.pixel_address = s1_addr;
  assign result.row_bits      = rd_data & COL_MASK;
  assign result.last_row      = s1_last;
  assign result.cursor_col    = s1_cx;
  assign result.cursor_row    = s1_cy;

endmodule

### rtl/text_console_glyph_writer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_writer
// Text console writer: font row loads and character puts with cursor motion.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. A load
//   item writes one font row and gives no result; a put item gives
//   CHAR_HEIGHT results, one per glyph row, each shown for one cycle with
//   result_strobe high. The receiver cannot stall, so every strobe is final.
//   Registers are written over the cfg channel (cfg_ready is always high)
//   while the block is idle.
//   With the engine idle, the first row of a put passes the command queue,
//   the draw engine registers and the font read register to the result
//   ports. A put holds the draw engine for one font memory read per row; a
//   load writes its row on pop. A queued put starts on the last row of the
//   one before. busy rises when the two-entry command queue is full.
//   Reset clears the cursor to the top left, restores the register defaults
//   and empties the queue. The font memory is not cleared: every glyph row
//   must be loaded before it is drawn.
// ----------------------------------------------------------------------------
module text_console_glyph_writer import tcgw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  output logic        result_strobe,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;
  cmd_t push_cmd, head;
  logic accept, push, pop, empty, full;

  assign cfg_ready = 1'b1;
  assign busy      = full;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width       <= 11'd128;
      cfg.text_area_height <= 11'd74;
      cfg.text_top_row     <= 10'd12;
      cfg.fg_color         <= 32'h00FF_FFFF;
      cfg.bg_color         <= 32'h0000_00FF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_WIDTH:  cfg.line_width       <= cfg_data[10:0];
        REG_TEXT_HEIGHT: cfg.text_area_height <= cfg_data[10:0];
        REG_TEXT_TOP:    cfg.text_top_row     <= cfg_data[9:0];
        REG_FG_COLOR:    cfg.fg_color         <= cfg_data;
        REG_BG_COLOR:    cfg.bg_color         <= cfg_data;
        default: ;
      endcase
    end
  end

  tcgw_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .push   (push),
    .cmd    (push_cmd)
  );

  tcgw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  tcgw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

### rtl/tcgw_checker.sv
// ----------------------------------------------------------------------------
// tcgw_checker
// Port-level checks on the result stream of the glyph writer.
// ----------------------------------------------------------------------------
module tcgw_checker import tcgw_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_strobe,
  input out_item_t result
);

  // no result right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !result_strobe)
    else $error("result strobe right after reset");

  // rows of one character come without gaps
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last_row |=> result_strobe)
    else $error("gap inside a character");

  // cursor fields hold over one character
  a_cursor_steady: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last_row |=>
      result.cursor_col == $past(result.cursor_col) &&
      result.cursor_row == $past(result.cursor_row))
    else $error("cursor changed inside a character");

  // a final row closes a full run of rows
  a_full_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last_row |->
      $past(result_strobe, CHAR_HEIGHT - 1))
    else $error("character ended early");

endmodule

bind text_console_glyph_writer tcgw_checker u_tcgw_checker (
  .clk           (clk),
  .rst           (rst),
  .result_strobe (result_strobe),
  .result        (result)
);

### test/tb_text_console_glyph_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_glyph_writer
// Self-checking bench for the text console glyph writer. The glyphs that
// puts draw are loaded first. Directed puts then cover register defaults,
// high codes, line wrap, last-row step back, backspace across lines and
// short lines. Random traffic follows under several register settings.
// Every glyph row result is compared field by field against a local cursor
// and font model.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_writer;
  import tcgw_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 2 * CHAR_HEIGHT + 8;
  localparam int MAX_GAP       = 18;
  localparam int PHASE_ITEMS   = 40;
  localparam int FONT_GLYPHS   = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    item;
  logic        result_strobe;
  out_item_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // model state
  cfg_t             model_cfg;
  logic [CUR_W-1:0] cur_x;
  logic [CUR_W-1:0] cur_y;
  logic [7:0]       font_mem [FONT_DEPTH];
  out_item_t        pending_rows [$];

  int fail_count    = 0;
  int rows_checked  = 0;
  int put_count     = 0;
  int load_count    = 0;
  int dropped_count = 0;
  int setting_count = 0;
  int cycle_count   = 0;
  int burst_left    = 0;

  text_console_glyph_writer i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int inc_clamp(input int a, input int b);
    return (a + b > int'(CUR_MAX)) ? int'(CUR_MAX) : a + b;
  endfunction

  function automatic int dec_clamp(input int a, input int b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic bit is_dropped_load(input in_item_t it);
    return it.opcode == OP_LOAD &&
           (int'(it.char_code) >= GLYPH_COUNT || int'(it.glyph_row) >= CHAR_HEIGHT);
  endfunction

  // glyphs that puts may draw: glyph 0, the substitute, space for
  // backspace, a few letters and the top glyph
  function automatic logic [7:0] font_glyph(input int k);
    logic [7:0] g;
    case (k)
      0:       g = 8'd0;
      1:       g = SUBST_GLYPH;
      2:       g = SPACE_CODE;
      3:       g = 8'h41;
      4:       g = 8'h42;
      5:       g = 8'h78;
      6:       g = 8'h79;
      default: g = HIGH_CODE_LIMIT;
    endcase
    return g;
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Font row write or cursor move plus CHAR_HEIGHT expected glyph rows.
  task automatic predict_glyph_rows(input in_item_t it);
    int        x;
    int        y;
    int        lw;
    int        dx;
    int        dy;
    int        gl;
    int        i;
    longint    addr;
    out_item_t r;
    if (it.opcode == OP_LOAD) begin
      if (is_dropped_load(it)) begin
        dropped_count++;
      end else begin
        font_mem[int'(it.char_code) * CHAR_HEIGHT + int'(it.glyph_row)] = it.glyph_bits;
        load_count++;
      end
      return;
    end
    put_count++;
    x  = int'(cur_x);
    y  = int'(cur_y);
    lw = int'(model_cfg.line_width);
    if (x != 0 && x >= lw) begin
      if (y + 2 * CHAR_HEIGHT <= int'(model_cfg.text_area_height)) begin
        x = 0;
        y = inc_clamp(y, CHAR_HEIGHT);
      end else begin
        x = dec_clamp(x, CHAR_WIDTH);
      end
    end
    if (it.char_code == BACKSPACE_CODE) begin
      if (x != 0) begin
        x = dec_clamp(x, CHAR_WIDTH);
      end else if (y > 0) begin
        y = dec_clamp(y, CHAR_HEIGHT);
        x = dec_clamp(lw, CHAR_WIDTH);
      end
      gl = int'(SPACE_CODE);
      dx = x;
      dy = y;
    end else begin
      gl = int'(it.char_code);
      dx = x;
      dy = y;
      x  = inc_clamp(x, CHAR_WIDTH);
    end
    if (gl > int'(HIGH_CODE_LIMIT) || gl >= GLYPH_COUNT) gl = int'(SUBST_GLYPH);
    cur_x = CUR_W'(x);
    cur_y = CUR_W'(y);
    for (i = 0; i < CHAR_HEIGHT; i++) begin
      addr = longint'(dx) +
             longint'(lw) * (longint'(model_cfg.text_top_row) + longint'(dy) + longint'(i));
      r.pixel_address = ADDR_W'(addr);
      r.row_bits      = font_mem[gl * CHAR_HEIGHT + i] & COL_MASK;
      r.last_row      = (i == CHAR_HEIGHT - 1);
      r.cursor_col    = cur_x;
      r.cursor_row    = cur_y;
      pending_rows.push_back(r);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected glyph row: %p", result);
        fail_count++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        check_field("pixel_address", 32'(want.pixel_address), 32'(result.pixel_address));
        check_field("row_bits", 32'(want.row_bits), 32'(result.row_bits));
        check_field("last_row", 32'(want.last_row), 32'(result.last_row));
        check_field("cursor_col", 32'(want.cursor_col), 32'(result.cursor_col));
        check_field("cursor_row", 32'(want.cursor_row), 32'(result.cursor_row));
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item  = it;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_glyph_rows(it);
  endtask

  task automatic put_char(input logic [7:0] code);
    in_item_t it;
    it.opcode     = OP_PUT;
    it.char_code  = code;
    it.glyph_row  = 4'($urandom);
    it.glyph_bits = 8'($urandom);
    send_item(it);
  endtask

  task automatic load_row(input logic [7:0] code, input logic [3:0] row,
                          input logic [7:0] bits);
    in_item_t it;
    it.opcode     = OP_LOAD;
    it.char_code  = code;
    it.glyph_row  = row;
    it.glyph_bits = bits;
    send_item(it);
  endtask

  // loads give no result, so allow the engine to finish after the last row
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_LINE_WIDTH:  model_cfg.line_width       = data[10:0];
      REG_TEXT_HEIGHT: model_cfg.text_area_height = data[10:0];
      REG_TEXT_TOP:    model_cfg.text_top_row     = data[9:0];
      REG_FG_COLOR:    model_cfg.fg_color         = data;
      REG_BG_COLOR:    model_cfg.bg_color         = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input int lw, input int tah, input int top,
                               input logic [31:0] fg, input logic [31:0] bg);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 32'(lw));
    write_reg(REG_TEXT_HEIGHT, 32'(tah));
    write_reg(REG_TEXT_TOP, 32'(top));
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    setting_count++;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       sel;
    sel           = $urandom_range(0, 99);
    it.opcode     = OP_PUT;
    it.char_code  = font_glyph($urandom_range(0, FONT_GLYPHS - 1));
    it.glyph_row  = 4'($urandom);
    it.glyph_bits = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      it.char_code = 8'($urandom_range(129, 255));
    end
    if (sel >= 72 && sel < 82) begin
      it.char_code = BACKSPACE_CODE;
    end else if (sel >= 82 && sel < 94) begin
      it.opcode    = OP_LOAD;
      it.char_code = 8'($urandom_range(0, GLYPH_COUNT - 1));
      it.glyph_row = 4'($urandom_range(0, CHAR_HEIGHT - 1));
    end else if (sel >= 94) begin
      it.opcode = OP_LOAD;
      if ($urandom_range(0, 1)) begin
        it.char_code = 8'($urandom_range(GLYPH_COUNT, 255));
      end else begin
        it.glyph_row = 4'($urandom_range(CHAR_HEIGHT, 15));
      end
    end
    return it;
  endfunction

  task automatic run_random_phase(input int n);
    int       done;
    in_item_t it;
    done = 0;
    while (done < n) begin
      it = random_item();
      if ($urandom_range(0, 49) == 0) wait_idle();
      send_item(it);
      if (!is_dropped_load(it)) done++;
    end
  endtask

  // puts only draw these glyphs, so their rows are loaded up front
  task automatic test_font_load();
    int         k;
    int         r;
    logic [7:0] g;
    for (k = 0; k < FONT_GLYPHS; k++) begin
      g = font_glyph(k);
      for (r = 0; r < CHAR_HEIGHT; r++) begin
        if (g == 8'd0) load_row(g, 4'(r), r[0] ? 8'hFF : 8'h00);
        else           load_row(g, 4'(r), 8'($urandom));
      end
    end
    load_row(8'd129, 4'd0, 8'hFF);
    load_row(8'd255, 4'd15, 8'hA5);
    load_row(8'd0, 4'd12, 8'h5A);
    load_row(8'd128, 4'd15, 8'hFF);
  endtask

  task automatic test_reset_defaults();
    put_char(BACKSPACE_CODE);
    put_char(8'd0);
    put_char(8'd255);
    put_char(HIGH_CODE_LIMIT);
    put_char(8'd129);
  endtask

  // three text rows of two cells: wrap, step back on the last row,
  // backspace across line starts
  task automatic test_cursor_motion();
    apply_setting(16, 36, 0, 32'h0000_0000, 32'hFFFF_FFFF);
    repeat (6) put_char(8'h41);
    repeat (4) put_char(BACKSPACE_CODE);
    repeat (2) put_char(8'h42);
    repeat (2) put_char(BACKSPACE_CODE);
  endtask

  task automatic test_short_line();
    apply_setting(5, 1024, 3, 32'hFFFF_FFFF, 32'h0000_0000);
    put_char(8'h78);
    put_char(8'h79);
    repeat (3) put_char(BACKSPACE_CODE);
  endtask

  task automatic test_random_traffic();
    apply_setting(128, 74, 12, 32'h00FF_FFFF, 32'h0000_00FF);
    run_random_phase(PHASE_ITEMS);
    apply_setting(8, 12, 0, 32'h0000_0000, 32'hFFFF_FFFF);
    run_random_phase(PHASE_ITEMS);
    apply_setting(1024, 1024, 1023, 32'hFFFF_FFFF, 32'h0000_0000);
    run_random_phase(PHASE_ITEMS);
    apply_setting(64, 48, 1023, $urandom, $urandom);
    run_random_phase(PHASE_ITEMS);
    apply_setting(8, 1024, 500, $urandom, $urandom);
    run_random_phase(PHASE_ITEMS);
    apply_setting($urandom_range(8, 96), $urandom_range(12, 120), $urandom_range(0, 1023),
                  $urandom, $urandom);
    run_random_phase(PHASE_ITEMS);
    apply_setting(1024, 12, 0, $urandom, $urandom);
    run_random_phase(PHASE_ITEMS);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    model_cfg = '{line_width: 11'd128, text_area_height: 11'd74, text_top_row: 10'd12,
                  fg_color: 32'h00FF_FFFF, bg_color: 32'h0000_00FF};
    cur_x     = '0;
    cur_y     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_font_load();
    test_reset_defaults();
    test_cursor_motion();
    test_short_line();
    test_random_traffic();
    wait_idle();

    $display("Ran %0d puts, %0d font loads and %0d dropped loads over %0d register settings",
             put_count, load_count, dropped_count, setting_count);
    $display("Checked %0d glyph rows, %0d errors", rows_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
